>>> rtl/fac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fac_pkg;

    localparam int PRESSURE_LEN = 7;
    localparam int TEXT_LEN     = 4;

    localparam int PCNT_W     = $clog2(PRESSURE_LEN + 1);
    localparam int PIDX_W     = $clog2(PRESSURE_LEN);
    localparam int TCNT_W     = $clog2(TEXT_LEN + 1);
    localparam int TIDX_W     = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
    localparam int TEXT_SHOWN = (TEXT_LEN < 4) ? TEXT_LEN : 4;

    localparam logic [7:0] CH_P_OPEN  = 8'h3B;  // ;
    localparam logic [7:0] CH_P_CLOSE = 8'h3A;  // :
    localparam logic [7:0] CH_H_OPEN  = 8'h7B;  // {
    localparam logic [7:0] CH_H_CLOSE = 8'h7D;  // }
    localparam logic [7:0] CH_W_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_W_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CH_SEP_LO  = 8'h78;  // x
    localparam logic [7:0] CH_SEP_UP  = 8'h58;  // X
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [9:0] VAL_MAX = 10'd999;
    localparam logic [9:0] VAL_SAT = 10'd1000;

    localparam logic [1:0] KIND_PRESSURE = 2'd0;
    localparam logic [1:0] KIND_HEIGHT   = 2'd1;
    localparam logic [1:0] KIND_WEIGHT   = 2'd2;

    typedef struct packed {
        logic step;   // take the beat on the input side
        logic scan;   // advance the pressure scan by one character
        logic emit;   // load the next pending result into the output register
    } fac_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic pend_any;
        logic pend_last;
        logic out_free;
    } fac_status_t;

endpackage

`default_nettype wire

>>> rtl/fac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fac_ctrl import fac_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire fac_status_t status,
    output fac_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.step   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.scan_busy) begin
                    state_next = ST_SCAN;
                end else if (status.pend_any) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (!status.scan_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.pend_any) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.pend_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

>>> rtl/fac_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fac_datapath import fac_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [7:0]   s_rx_byte,
    input  wire fac_cmd_t     cmd,
    output fac_status_t       status,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_field_kind,
    output logic              m_field_error,
    output logic [9:0]        m_high_value,
    output logic [9:0]        m_low_value,
    output logic [31:0]       m_text_bytes,
    output logic [2:0]        m_text_length,
    output logic              m_last_result
);

    // pending results, lowest bit goes out first
    localparam int PEND_W_OVF = 0;
    localparam int PEND_P_OVF = 1;
    localparam int PEND_H_OVF = 2;
    localparam int PEND_H_TXT = 3;
    localparam int PEND_W_TXT = 4;
    localparam int PEND_P_RES = 5;
    localparam int PEND_N     = 6;

    typedef enum logic [1:0] {
        SC_SKIP,
        SC_DIG,
        SC_END
    } sc_mode_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SEP_LO) || (c == CH_SEP_UP);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic val_ok(input logic [9:0] v, input logic neg);
        return (v <= VAL_MAX) && !(neg && (v != 10'd0));
    endfunction

    // collectors
    logic              p_open_reg, p_open_next;
    logic              h_open_reg, h_open_next;
    logic              w_open_reg, w_open_next;
    logic [PCNT_W-1:0] p_cnt_reg, p_cnt_next;
    logic [TCNT_W-1:0] h_cnt_reg, h_cnt_next;
    logic [TCNT_W-1:0] w_cnt_reg, w_cnt_next;
    logic [7:0]        p_chars_reg [PRESSURE_LEN];
    logic [7:0]        h_chars_reg [TEXT_LEN];
    logic [7:0]        w_chars_reg [TEXT_LEN];

    logic [PEND_N-1:0] pend_reg, pend_next;

    // pressure scan
    logic              scan_busy_reg, scan_busy_next;
    logic [PCNT_W-1:0] sc_idx_reg, sc_idx_next;
    logic              sc_sep_reg, sc_sep_next;
    sc_mode_t          sc_mode_reg, sc_mode_next;
    logic              sc_neg_reg, sc_neg_next;
    logic [9:0]        sc_val_reg, sc_val_next;
    logic [9:0]        hi_val_reg, hi_val_next;
    logic              hi_neg_reg, hi_neg_next;
    logic              p_err_reg, p_err_next;
    logic [9:0]        p_hi_reg, p_hi_next;
    logic [9:0]        p_lo_reg, p_lo_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic              err_reg, err_next;
    logic [9:0]        hiv_reg, hiv_next;
    logic [9:0]        lov_reg, lov_next;
    logic [31:0]       text_reg, text_next;
    logic [2:0]        tlen_reg, tlen_next;
    logic              last_reg, last_next;

    logic              is_data;
    logic              p_room, h_room, w_room;
    logic [7:0]        sc_char;
    logic              sc_at_end;
    logic [13:0]       sc_acc;
    logic [9:0]        sc_dig_val;
    logic [31:0]       h_text, w_text;
    logic              out_free;
    logic              pend_last;

    assign is_data = (s_rx_byte != CH_P_OPEN) && (s_rx_byte != CH_P_CLOSE) &&
                     (s_rx_byte != CH_H_OPEN) && (s_rx_byte != CH_H_CLOSE) &&
                     (s_rx_byte != CH_W_OPEN) && (s_rx_byte != CH_W_CLOSE);
    assign p_room  = p_cnt_reg < PCNT_W'(PRESSURE_LEN);
    assign h_room  = h_cnt_reg < TCNT_W'(TEXT_LEN);
    assign w_room  = w_cnt_reg < TCNT_W'(TEXT_LEN);

    assign sc_char   = (sc_idx_reg < p_cnt_reg) ?
                       p_chars_reg[sc_idx_reg[PIDX_W-1:0]] : 8'h00;
    assign sc_at_end = (sc_idx_reg == p_cnt_reg) || (sc_sep_reg && is_sep(sc_char));
    assign sc_acc    = (14'(sc_val_reg) << 3) + (14'(sc_val_reg) << 1) +
                       14'(sc_char - CH_ZERO);
    assign sc_dig_val = (sc_acc > 14'(VAL_MAX)) ? VAL_SAT : sc_acc[9:0];

    always_comb begin
        h_text = '0;
        w_text = '0;
        for (int i = 0; i < TEXT_SHOWN; i++) begin
            if (TCNT_W'(i) < h_cnt_reg) begin
                h_text[8*i +: 8] = h_chars_reg[i];
            end
            if (TCNT_W'(i) < w_cnt_reg) begin
                w_text[8*i +: 8] = w_chars_reg[i];
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign pend_last = (pend_reg != '0) && ((pend_reg & (pend_reg - 1'b1)) == '0);

    always_comb begin
        p_open_next    = p_open_reg;
        h_open_next    = h_open_reg;
        w_open_next    = w_open_reg;
        p_cnt_next     = p_cnt_reg;
        h_cnt_next     = h_cnt_reg;
        w_cnt_next     = w_cnt_reg;
        pend_next      = pend_reg;
        scan_busy_next = scan_busy_reg;
        sc_idx_next    = sc_idx_reg;
        sc_sep_next    = sc_sep_reg;
        sc_mode_next   = sc_mode_reg;
        sc_neg_next    = sc_neg_reg;
        sc_val_next    = sc_val_reg;
        hi_val_next    = hi_val_reg;
        hi_neg_next    = hi_neg_reg;
        p_err_next     = p_err_reg;
        p_hi_next      = p_hi_reg;
        p_lo_next      = p_lo_reg;
        m_valid_next   = m_valid_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        hiv_next       = hiv_reg;
        lov_next       = lov_reg;
        text_next      = text_reg;
        tlen_next      = tlen_reg;
        last_next      = last_reg;

        if (cmd.step) begin
            unique case (s_rx_byte)
                CH_P_OPEN: begin
                    p_open_next = 1'b1;
                    p_cnt_next  = '0;
                end
                CH_H_OPEN: begin
                    h_open_next = 1'b1;
                    h_cnt_next  = '0;
                end
                CH_W_OPEN: begin
                    w_open_next = 1'b1;
                    w_cnt_next  = '0;
                end
                CH_P_CLOSE: begin
                    if (p_open_reg) begin
                        p_open_next    = 1'b0;
                        scan_busy_next = 1'b1;
                        sc_idx_next    = '0;
                        sc_sep_next    = 1'b0;
                        sc_mode_next   = SC_SKIP;
                        sc_neg_next    = 1'b0;
                        sc_val_next    = '0;
                    end
                end
                CH_H_CLOSE: begin
                    if (h_open_reg) begin
                        h_open_next            = 1'b0;
                        pend_next[PEND_H_TXT]  = 1'b1;
                    end
                end
                CH_W_CLOSE: begin
                    if (w_open_reg) begin
                        w_open_next            = 1'b0;
                        pend_next[PEND_W_TXT]  = 1'b1;
                    end
                end
                default: begin
                    if (w_open_reg) begin
                        if (w_room) begin
                            w_cnt_next = w_cnt_reg + 1'b1;
                        end else begin
                            w_open_next           = 1'b0;
                            pend_next[PEND_W_OVF] = 1'b1;
                        end
                    end
                    if (p_open_reg) begin
                        if (p_room) begin
                            p_cnt_next = p_cnt_reg + 1'b1;
                        end else begin
                            p_open_next           = 1'b0;
                            pend_next[PEND_P_OVF] = 1'b1;
                        end
                    end
                    if (h_open_reg) begin
                        if (h_room) begin
                            h_cnt_next = h_cnt_reg + 1'b1;
                        end else begin
                            h_open_next           = 1'b0;
                            pend_next[PEND_H_OVF] = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (cmd.scan && scan_busy_reg) begin
            if (sc_at_end) begin
                scan_busy_next        = 1'b0;
                pend_next[PEND_P_RES] = 1'b1;
                p_err_next = !sc_sep_reg || !val_ok(hi_val_reg, hi_neg_reg) ||
                             !val_ok(sc_val_reg, sc_neg_reg);
                p_hi_next  = p_err_next ? 10'd0 : hi_val_reg;
                p_lo_next  = p_err_next ? 10'd0 : sc_val_reg;
            end else begin
                sc_idx_next = sc_idx_reg + 1'b1;
                if (!sc_sep_reg && is_sep(sc_char)) begin
                    // close the first number, start the second
                    hi_val_next  = sc_val_reg;
                    hi_neg_next  = sc_neg_reg;
                    sc_sep_next  = 1'b1;
                    sc_mode_next = SC_SKIP;
                    sc_neg_next  = 1'b0;
                    sc_val_next  = '0;
                end else begin
                    case (sc_mode_reg)
                        SC_SKIP: begin
                            if (is_blank(sc_char)) begin
                                sc_mode_next = SC_SKIP;
                            end else if (sc_char == CH_PLUS || sc_char == CH_MINUS) begin
                                sc_neg_next  = (sc_char == CH_MINUS);
                                sc_mode_next = SC_DIG;
                            end else if (is_digit(sc_char)) begin
                                sc_val_next  = sc_dig_val;
                                sc_mode_next = SC_DIG;
                            end else begin
                                sc_mode_next = SC_END;
                            end
                        end
                        SC_DIG: begin
                            if (is_digit(sc_char)) begin
                                sc_val_next = sc_dig_val;
                            end else begin
                                sc_mode_next = SC_END;
                            end
                        end
                        default: sc_mode_next = SC_END;
                    endcase
                end
            end
        end

        if (cmd.emit && out_free && (pend_reg != '0)) begin
            m_valid_next = 1'b1;
            err_next     = 1'b1;
            hiv_next     = '0;
            lov_next     = '0;
            text_next    = '0;
            tlen_next    = '0;
            last_next    = pend_last;
            if (pend_reg[PEND_W_OVF]) begin
                kind_next             = KIND_WEIGHT;
                pend_next[PEND_W_OVF] = 1'b0;
            end else if (pend_reg[PEND_P_OVF]) begin
                kind_next             = KIND_PRESSURE;
                pend_next[PEND_P_OVF] = 1'b0;
            end else if (pend_reg[PEND_H_OVF]) begin
                kind_next             = KIND_HEIGHT;
                pend_next[PEND_H_OVF] = 1'b0;
            end else if (pend_reg[PEND_H_TXT]) begin
                kind_next             = KIND_HEIGHT;
                err_next              = 1'b0;
                text_next             = h_text;
                tlen_next             = 3'(h_cnt_reg);
                pend_next[PEND_H_TXT] = 1'b0;
            end else if (pend_reg[PEND_W_TXT]) begin
                kind_next             = KIND_WEIGHT;
                err_next              = 1'b0;
                text_next             = w_text;
                tlen_next             = 3'(w_cnt_reg);
                pend_next[PEND_W_TXT] = 1'b0;
            end else begin
                kind_next             = KIND_PRESSURE;
                err_next              = p_err_reg;
                hiv_next              = p_hi_reg;
                lov_next              = p_lo_reg;
                pend_next[PEND_P_RES] = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_open_reg    <= 1'b0;
            h_open_reg    <= 1'b0;
            w_open_reg    <= 1'b0;
            p_cnt_reg     <= '0;
            h_cnt_reg     <= '0;
            w_cnt_reg     <= '0;
            pend_reg      <= '0;
            scan_busy_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p_open_reg    <= p_open_next;
            h_open_reg    <= h_open_next;
            w_open_reg    <= w_open_next;
            p_cnt_reg     <= p_cnt_next;
            h_cnt_reg     <= h_cnt_next;
            w_cnt_reg     <= w_cnt_next;
            pend_reg      <= pend_next;
            scan_busy_reg <= scan_busy_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sc_idx_reg  <= sc_idx_next;
        sc_sep_reg  <= sc_sep_next;
        sc_mode_reg <= sc_mode_next;
        sc_neg_reg  <= sc_neg_next;
        sc_val_reg  <= sc_val_next;
        hi_val_reg  <= hi_val_next;
        hi_neg_reg  <= hi_neg_next;
        p_err_reg   <= p_err_next;
        p_hi_reg    <= p_hi_next;
        p_lo_reg    <= p_lo_next;
        kind_reg    <= kind_next;
        err_reg     <= err_next;
        hiv_reg     <= hiv_next;
        lov_reg     <= lov_next;
        text_reg    <= text_next;
        tlen_reg    <= tlen_next;
        last_reg    <= last_next;
    end

    // store data characters into every open collector with room
    always_ff @(posedge aclk) begin
        if (cmd.step && is_data) begin
            if (p_open_reg && p_room) begin
                p_chars_reg[p_cnt_reg[PIDX_W-1:0]] <= s_rx_byte;
            end
            if (h_open_reg && h_room) begin
                h_chars_reg[h_cnt_reg[TIDX_W-1:0]] <= s_rx_byte;
            end
            if (w_open_reg && w_room) begin
                w_chars_reg[w_cnt_reg[TIDX_W-1:0]] <= s_rx_byte;
            end
        end
    end

    assign status.scan_busy = scan_busy_reg;
    assign status.pend_any  = (pend_reg != '0);
    assign status.pend_last = pend_last;
    assign status.out_free  = out_free;

    assign m_valid       = m_valid_reg;
    assign m_field_kind  = kind_reg;
    assign m_field_error = err_reg;
    assign m_high_value  = hiv_reg;
    assign m_low_value   = lov_reg;
    assign m_text_bytes  = text_reg;
    assign m_text_length = tlen_reg;
    assign m_last_result = last_reg;

endmodule

`default_nettype wire

>>> rtl/framed_ascii_field_collector_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// input     s_valid / s_ready  s_rx_byte
// result    m_valid / m_ready  m_field_kind, m_field_error, m_high_value,
//                              m_low_value, m_text_bytes, m_text_length,
//                              m_last_result
//
// One byte at a time: s_ready stays low while a byte is decoded and its
// results are emitted. A pressure close walks the stored characters once,
// one per cycle, before its result is queued.
// Reset is synchronous and active low; all collectors come up closed.
// A stalled result beat holds the sequencer in its emit step; the input
// side reopens as soon as the final result is in the output register.

module framed_ascii_field_collector_unit import fac_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_field_kind,
    output logic             m_field_error,
    output logic [9:0]       m_high_value,
    output logic [9:0]       m_low_value,
    output logic [31:0]      m_text_bytes,
    output logic [2:0]       m_text_length,
    output logic             m_last_result
);

    fac_cmd_t    cmd;
    fac_status_t status;

    fac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fac_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_rx_byte     (s_rx_byte),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_kind  (m_field_kind),
        .m_field_error (m_field_error),
        .m_high_value  (m_high_value),
        .m_low_value   (m_low_value),
        .m_text_bytes  (m_text_bytes),
        .m_text_length (m_text_length),
        .m_last_result (m_last_result)
    );

endmodule

`default_nettype wire

>>> test/framed_ascii_field_collector_unit_tb.sv
`timescale 1ns / 1ps

module framed_ascii_field_collector_unit_tb;
    import fac_pkg::*;

    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [1:0]  kind;
        logic        err;
        logic [9:0]  hi;
        logic [9:0]  lo;
        logic [31:0] text;
        logic [2:0]  len;
        logic        last;
    } field_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_field_kind;
    logic        m_field_error;
    logic [9:0]  m_high_value;
    logic [9:0]  m_low_value;
    logic [31:0] m_text_bytes;
    logic [2:0]  m_text_length;
    logic        m_last_result;

    framed_ascii_field_collector_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_kind  (m_field_kind),
        .m_field_error (m_field_error),
        .m_high_value  (m_high_value),
        .m_low_value   (m_low_value),
        .m_text_bytes  (m_text_bytes),
        .m_text_length (m_text_length),
        .m_last_result (m_last_result)
    );

    always #2 aclk = ~aclk;

    // Collector state as seen by the predictor
    bit                        p_open, h_open, w_open;
    int                        p_cnt, h_cnt, w_cnt;
    bit [7:0]                  p_buf [PRESSURE_LEN];
    bit [TEXT_LEN-1:0][7:0]    h_buf, w_buf;

    field_result_t pending_fields[$];
    bit [7:0]      frame_q[$];

    int  error_count  = 0;
    int  sent_count   = 0;
    int  result_count = 0;
    int  error_fields = 0;
    int  kind_count [3];
    bit  in_idle_on   = 1'b1;
    bit  out_idle_on  = 1'b1;
    int  ready_hold   = 0;

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        return (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic int input_gap();
        if (!in_idle_on || $urandom_range(0, 99) >= 30)
            return 0;
        return stall_len();
    endfunction

    function automatic field_result_t make_result(logic [1:0] kind, logic err,
                                                  logic [9:0] hi, logic [9:0] lo,
                                                  logic [31:0] text, logic [2:0] len);
        field_result_t r;
        r = {kind, err, hi, lo, text, len, 1'b0};
        return r;
    endfunction

    function automatic bit is_blank(bit [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_sep(bit [7:0] c);
        return c == CH_SEP_LO || c == CH_SEP_UP;
    endfunction

    // atoi over p_buf[b..e), saturating at 1000; returns 1 when in range
    function automatic bit parse_part(int b, int e, output int val);
        int i;
        int v;
        bit neg;
        i = b;
        v = 0;
        neg = 1'b0;
        while (i < e && is_blank(p_buf[i]))
            i++;
        if (i < e && (p_buf[i] == CH_PLUS || p_buf[i] == CH_MINUS)) begin
            neg = (p_buf[i] == CH_MINUS);
            i++;
        end
        while (i < e && p_buf[i] >= CH_ZERO && p_buf[i] <= CH_NINE) begin
            v = v * 10 + int'(p_buf[i] - CH_ZERO);
            if (v > int'(VAL_MAX))
                v = int'(VAL_SAT);
            i++;
        end
        val = v;
        return !(neg && v != 0) && v <= int'(VAL_MAX);
    endfunction

    function automatic field_result_t pressure_outcome();
        int s;
        int e;
        int hi;
        int lo;
        bit ok;
        s = 0;
        while (s < p_cnt && !is_sep(p_buf[s]))
            s++;
        if (s >= p_cnt)
            return make_result(KIND_PRESSURE, 1'b1, '0, '0, '0, '0);
        e = s + 1;
        while (e < p_cnt && !is_sep(p_buf[e]))
            e++;
        ok = parse_part(0, s, hi);
        ok = parse_part(s + 1, e, lo) && ok;
        if (!ok)
            return make_result(KIND_PRESSURE, 1'b1, '0, '0, '0, '0);
        return make_result(KIND_PRESSURE, 1'b0, hi[9:0], lo[9:0], '0, '0);
    endfunction

    function automatic field_result_t text_outcome(logic [1:0] kind,
                                                   bit [TEXT_LEN-1:0][7:0] chars, int cnt);
        logic [31:0] text;
        text = '0;
        for (int i = 0; i < cnt && i < TEXT_SHOWN; i++)
            text[8*i +: 8] = chars[i];
        return make_result(kind, 1'b0, '0, '0, text, cnt[2:0]);
    endfunction

    // Returns 1 when the collector was full and closes on this byte
    function automatic bit text_append(inout bit open, inout int cnt,
                                       inout bit [TEXT_LEN-1:0][7:0] chars,
                                       input bit [7:0] c);
        if (!open)
            return 1'b0;
        if (cnt < TEXT_LEN) begin
            chars[cnt] = c;
            cnt++;
            return 1'b0;
        end
        open = 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_collectors(input bit [7:0] c);
        field_result_t out_q[$];
        case (c)
            CH_P_OPEN: begin
                p_open = 1'b1;
                p_cnt = 0;
            end
            CH_H_OPEN: begin
                h_open = 1'b1;
                h_cnt = 0;
            end
            CH_W_OPEN: begin
                w_open = 1'b1;
                w_cnt = 0;
            end
            CH_P_CLOSE: begin
                if (p_open) begin
                    p_open = 1'b0;
                    out_q.push_back(pressure_outcome());
                end
            end
            CH_H_CLOSE: begin
                if (h_open) begin
                    h_open = 1'b0;
                    out_q.push_back(text_outcome(KIND_HEIGHT, h_buf, h_cnt));
                end
            end
            CH_W_CLOSE: begin
                if (w_open) begin
                    w_open = 1'b0;
                    out_q.push_back(text_outcome(KIND_WEIGHT, w_buf, w_cnt));
                end
            end
            default: begin
                // overflow errors come out weight, pressure, height
                if (text_append(w_open, w_cnt, w_buf, c))
                    out_q.push_back(make_result(KIND_WEIGHT, 1'b1, '0, '0, '0, '0));
                if (p_open) begin
                    if (p_cnt < PRESSURE_LEN) begin
                        p_buf[p_cnt] = c;
                        p_cnt++;
                    end else begin
                        p_open = 1'b0;
                        out_q.push_back(make_result(KIND_PRESSURE, 1'b1, '0, '0, '0, '0));
                    end
                end
                if (text_append(h_open, h_cnt, h_buf, c))
                    out_q.push_back(make_result(KIND_HEIGHT, 1'b1, '0, '0, '0, '0));
            end
        endcase
        if (out_q.size() > 0)
            out_q[out_q.size() - 1].last = 1'b1;
        foreach (out_q[i])
            pending_fields.push_back(out_q[i]);
    endtask

    // Leaves s_valid high after the beat; the caller drives the next step at once
    task automatic send_byte(input bit [7:0] b);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_collectors(b);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_frame_q();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
    endtask

    function automatic bit [7:0] rand_data_byte();
        bit [7:0] c;
        do begin
            c = $urandom_range(0, 255);
        end while (c == CH_P_OPEN || c == CH_P_CLOSE || c == CH_H_OPEN ||
                   c == CH_H_CLOSE || c == CH_W_OPEN || c == CH_W_CLOSE);
        return c;
    endfunction

    function automatic bit [7:0] rand_sep();
        return $urandom_range(0, 1) ? CH_SEP_LO : CH_SEP_UP;
    endfunction

    task automatic build_number();
        int r;
        int nd;
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0: frame_q.push_back(CH_SPACE);
                1: frame_q.push_back(CH_TAB);
                2: frame_q.push_back(CH_CR);
                default: frame_q.push_back(CH_LF);
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            frame_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        r = $urandom_range(0, 99);
        nd = (r < 85) ? $urandom_range(1, 3) : ((r < 93) ? 0 : 4);
        repeat (nd) frame_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_pressure_frame();
        frame_q.delete();
        frame_q.push_back(CH_P_OPEN);
        build_number();
        if ($urandom_range(0, 9) != 0)
            frame_q.push_back(rand_sep());
        build_number();
        if ($urandom_range(0, 5) == 0) begin
            frame_q.push_back(rand_sep());
            frame_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0)
            frame_q.insert($urandom_range(1, frame_q.size()), rand_data_byte());
        if ($urandom_range(0, 19) != 0)
            frame_q.push_back(CH_P_CLOSE);
        send_frame_q();
    endtask

    task automatic send_text_frame(input bit [7:0] open_ch, input bit [7:0] close_ch);
        frame_q.delete();
        frame_q.push_back(open_ch);
        repeat ($urandom_range(0, TEXT_LEN + 1)) frame_q.push_back(rand_data_byte());
        if ($urandom_range(0, 9) != 0)
            frame_q.push_back(close_ch);
        send_frame_q();
    endtask

    // Overlapping frames: framing bytes mixed in among digits and data
    task automatic send_mixed_frames();
        frame_q.delete();
        repeat ($urandom_range(6, 14)) begin
            if ($urandom_range(0, 99) < 40) begin
                case ($urandom_range(0, 5))
                    0: frame_q.push_back(CH_P_OPEN);
                    1: frame_q.push_back(CH_P_CLOSE);
                    2: frame_q.push_back(CH_H_OPEN);
                    3: frame_q.push_back(CH_H_CLOSE);
                    4: frame_q.push_back(CH_W_OPEN);
                    default: frame_q.push_back(CH_W_CLOSE);
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: frame_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    1: frame_q.push_back(rand_sep());
                    default: frame_q.push_back(rand_data_byte());
                endcase
            end
        end
        send_frame_q();
    endtask

    task automatic test_close_inactive();
        send_text("}]:");
    endtask

    // Fill all three collectors, then one byte overflows them together
    task automatic test_overflow_order();
        send_text(";-0x{[1000");
        send_byte(8'hFF);
        send_byte(CH_P_CLOSE);
    endtask

    task automatic test_pressure_parse();
        send_text(";\t+5X999:");
        send_text(";-3:");
    endtask

    task automatic test_text_restart();
        send_byte(CH_H_OPEN);
        send_byte(8'h00);
        send_text("{z}[]");
    endtask

    task automatic test_drain_pause();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_fields.size() != 0);
    endtask

    task automatic test_random_traffic(input int upto);
        int r;
        while (sent_count < upto) begin
            if ($urandom_range(0, 9) == 0)
                in_idle_on = ~in_idle_on;
            if ($urandom_range(0, 9) == 0)
                out_idle_on = ~out_idle_on;
            r = $urandom_range(0, 99);
            if (r < 40)
                send_pressure_frame();
            else if (r < 58)
                send_text_frame(CH_H_OPEN, CH_H_CLOSE);
            else if (r < 76)
                send_text_frame(CH_W_OPEN, CH_W_CLOSE);
            else if (r < 88)
                send_mixed_frames();
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            ready_hold <= stall_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        field_result_t got;
        field_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_field_kind, m_field_error, m_high_value, m_low_value,
                   m_text_bytes, m_text_length, m_last_result};
            if (pending_fields.size() == 0) begin
                $display("%0t unexpected result: expected none, got kind %0d err %0d",
                         $time, got.kind, got.err);
                error_count++;
            end else begin
                want = pending_fields.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected kind %0d err %0d hi %0d lo %0d text %h len %0d last %0d",
                             $time, want.kind, want.err, want.hi, want.lo, want.text,
                             want.len, want.last);
                    $display("%0t            got kind %0d err %0d hi %0d lo %0d text %h len %0d last %0d",
                             $time, got.kind, got.err, got.hi, got.lo, got.text,
                             got.len, got.last);
                    error_count++;
                end
            end
            result_count++;
            if (got.err)
                error_fields++;
            if (got.kind <= KIND_WEIGHT)
                kind_count[got.kind]++;
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_close_inactive();
        test_overflow_order();
        test_pressure_parse();
        test_text_restart();
        test_drain_pause();
        test_random_traffic(180);
        test_drain_pause();
        test_random_traffic(360);

        s_valid <= 1'b0;
        waited = 0;
        while (pending_fields.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (pending_fields.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_fields.size());
            error_count++;
        end

        $display("Sent %0d bytes; checked %0d results (%0d pressure, %0d height, %0d weight)",
                 sent_count, result_count, kind_count[0], kind_count[1], kind_count[2]);
        $display("Flagged results: %0d; mismatches: %0d", error_fields, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
